// ===== sv/msc_pkg.sv =====
// ---------------------------------------------------------------------------
// MESI snoop coherence package
// Shared constants, state and status codes, and the result record.
// ---------------------------------------------------------------------------
package msc_pkg;

    localparam int NUM_CPUS_D   = 4;
    localparam int SETS_D       = 64;
    localparam int WAYS_D       = 4;
    localparam int LINE_BYTES_D = 64;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    localparam logic [2:0] RS_READ_HIT  = 3'd0;
    localparam logic [2:0] RS_MISS_SHR  = 3'd1;
    localparam logic [2:0] RS_MISS_OWN  = 3'd2;
    localparam logic [2:0] RS_MEM_READ  = 3'd3;
    localparam logic [2:0] RS_WRITE_HIT = 3'd4;
    localparam logic [2:0] RS_WRITE_MIS = 3'd5;
    localparam logic [2:0] RS_UPGRADE   = 3'd6;

    typedef struct packed {
        logic        others_invalidated;
        logic [1:0]  line_state;
        logic [31:0] writeback_addr;
        logic        writeback_valid;
        logic [31:0] mem_read_addr;
        logic        mem_read_valid;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== sv/msc_ram.sv =====
// ---------------------------------------------------------------------------
// MESI snoop coherence set memory
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ---------------------------------------------------------------------------
module msc_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/msc_eval.sv =====
// ---------------------------------------------------------------------------
// MESI snoop coherence set update
// Tag match, snoop, victim choice and LRU update over one set of all caches.
// ---------------------------------------------------------------------------
module msc_eval #(
    parameter int NUM_CPUS   = 4,
    parameter int WAYS       = 4,
    parameter int LINE_BYTES = 64,
    parameter int CPU_W      = 2,
    parameter int TAG_W      = 26,
    parameter int AGE_W      = 2,
    parameter int ENT_W      = 30
) (
    input  logic [CPU_W-1:0]               i_cpu,
    input  logic                           i_wr,
    input  logic [TAG_W-1:0]               i_tag,
    input  logic [NUM_CPUS*WAYS*ENT_W-1:0] i_rword,
    output logic [NUM_CPUS*WAYS*ENT_W-1:0] o_wword,
    output msc_pkg::t_result               o_res
);
    import msc_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [1:0]       st   [NUM_CPUS][WAYS];
    logic [AGE_W-1:0] age  [NUM_CPUS][WAYS];
    logic [TAG_W-1:0] tg   [NUM_CPUS][WAYS];
    logic             hitv [NUM_CPUS];
    logic [WAY_W-1:0] hitw [NUM_CPUS];
    logic [1:0]       cur;
    logic [1:0]       newst;
    logic             fill;
    logic             found;
    logic             vfound;
    logic [WAY_W-1:0] vic;
    logic [WAY_W-1:0] tw;
    logic [AGE_W-1:0] ta;
    logic [TAG_W-1:0] vtag;

    always_comb begin
        o_res = '0;
        fill  = 1'b0;
        found = 1'b0;
        newst = ST_I;
        for (int c = 0; c < NUM_CPUS; c++) begin
            hitv[c] = 1'b0;
            hitw[c] = '0;
            for (int w = 0; w < WAYS; w++) begin
                st[c][w]  = i_rword[(c*WAYS+w)*ENT_W +: 2];
                age[c][w] = i_rword[(c*WAYS+w)*ENT_W+2 +: AGE_W];
                tg[c][w]  = i_rword[(c*WAYS+w)*ENT_W+2+AGE_W +: TAG_W];
                if (!hitv[c] && st[c][w] != ST_I && tg[c][w] == i_tag) begin
                    hitv[c] = 1'b1;
                    hitw[c] = WAY_W'(w);
                end
            end
        end
        cur = hitv[i_cpu] ? st[i_cpu][hitw[i_cpu]] : ST_I;

        if (!i_wr) begin
            if (hitv[i_cpu]) begin
                o_res.status = RS_READ_HIT;
                newst        = cur;
            end else begin
                o_res.status = RS_MEM_READ;
                for (int c = 0; c < NUM_CPUS; c++) begin
                    if (!found && CPU_W'(c) != i_cpu && hitv[c]) begin
                        found = 1'b1;
                        if (st[c][hitw[c]] == ST_S) begin
                            o_res.status = RS_MISS_SHR;
                        end else begin
                            o_res.status     = RS_MISS_OWN;
                            st[c][hitw[c]] = ST_S;
                        end
                    end
                end
                if (!found) begin
                    o_res.mem_read_valid = 1'b1;
                    o_res.mem_read_addr  = 32'(40'(i_tag) * 40'(LINE_BYTES));
                    newst                = ST_E;
                end else begin
                    newst = ST_S;
                end
                fill = 1'b1;
            end
        end else begin
            newst = ST_M;
            if (cur == ST_M) begin
                o_res.status = RS_WRITE_HIT;
            end else begin
                for (int c = 0; c < NUM_CPUS; c++) begin
                    if (CPU_W'(c) != i_cpu && hitv[c]) begin
                        st[c][hitw[c]]           = ST_I;
                        o_res.others_invalidated = 1'b1;
                    end
                end
                if (hitv[i_cpu]) begin
                    o_res.status                 = RS_UPGRADE;
                    st[i_cpu][hitw[i_cpu]] = ST_M;
                end else begin
                    o_res.status = RS_WRITE_MIS;
                    fill         = 1'b1;
                end
            end
        end

        vfound = 1'b0;
        vic    = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!vfound && st[i_cpu][w] == ST_I) begin
                vfound = 1'b1;
                vic    = WAY_W'(w);
            end
        end
        if (!vfound) begin
            for (int w = 1; w < WAYS; w++) begin
                if (age[i_cpu][w] > age[i_cpu][vic]) begin
                    vic = WAY_W'(w);
                end
            end
        end
        vtag = tg[i_cpu][vic];
        if (fill) begin
            if (st[i_cpu][vic] == ST_M) begin
                o_res.writeback_valid = 1'b1;
                o_res.writeback_addr  = 32'(40'(vtag) * 40'(LINE_BYTES));
            end
            tg[i_cpu][vic] = i_tag;
            st[i_cpu][vic] = newst;
        end

        tw = fill ? vic : hitw[i_cpu];
        ta = age[i_cpu][tw];
        for (int w = 0; w < WAYS; w++) begin
            if (age[i_cpu][w] < ta) begin
                age[i_cpu][w] = age[i_cpu][w] + 1'b1;
            end
        end
        age[i_cpu][tw] = '0;

        o_res.line_state = newst;
        for (int c = 0; c < NUM_CPUS; c++) begin
            for (int w = 0; w < WAYS; w++) begin
                o_wword[(c*WAYS+w)*ENT_W +: ENT_W] = {tg[c][w], age[c][w], st[c][w]};
            end
        end
    end

endmodule

// ===== sv/mesi_snoop_coherence_top.sv =====
// ---------------------------------------------------------------------------
// MESI snoop coherence top level
// Each access is taken in S_IDLE, its set RAM read in S_RD, and in S_EV the
// update written back and the result registered once the output is free;
// no new access is taken until then. Reset: a clearing pass writes every
// set Invalid with ages in way order; no input is taken until it ends.
// ---------------------------------------------------------------------------
module mesi_snoop_coherence_top #(
    parameter int NUM_CPUS   = msc_pkg::NUM_CPUS_D,
    parameter int SETS       = msc_pkg::SETS_D,
    parameter int WAYS       = msc_pkg::WAYS_D,
    parameter int LINE_BYTES = msc_pkg::LINE_BYTES_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // requester[1:0], mode[2], address[34:3]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[2:0], mem_read_valid[3], mem_read_addr[35:4], writeback_valid[36],
    // writeback_addr[68:37], line_state[70:69], others_invalidated[71]
    output logic [71:0] o_m_tdata
);
    import msc_pkg::*;

    localparam int CPU_W = $clog2(NUM_CPUS);
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_W = 33 - $clog2(LINE_BYTES + 1);
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W = 2 + AGE_W + TAG_W;
    localparam int DW    = NUM_CPUS * WAYS * ENT_W;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EV   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [SET_W:0]   r_clr, n_clr;
    logic [CPU_W-1:0] r_cpu;
    logic             r_wr;
    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_set;
    logic             r_ovalid, n_ovalid;
    t_result          r_res;
    t_result          ev_res;
    logic [DW-1:0]    rdata, ev_word, rst_word, wdata;
    logic [SET_W-1:0] waddr;
    logic             we;
    logic             s_acc;
    logic             out_free;
    logic [1:0]       req;
    logic [31:0]      addr;
    logic [TAG_W-1:0] tag_in;

    assign req      = i_s_tdata[1:0];
    assign addr     = i_s_tdata[34:3];
    assign tag_in   = TAG_W'(addr / LINE_BYTES);
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;

    always_comb begin
        for (int c = 0; c < NUM_CPUS; c++) begin
            for (int w = 0; w < WAYS; w++) begin
                rst_word[(c*WAYS+w)*ENT_W +: ENT_W] =
                    {{TAG_W{1'b0}}, AGE_W'(w), ST_I};
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_ovalid = r_ovalid && !i_m_tready;
        we       = 1'b0;
        waddr    = r_set;
        wdata    = ev_word;
        unique case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr[SET_W-1:0];
                wdata = rst_word;
                n_clr = r_clr + 1'b1;
                if (r_clr == (SET_W+1)'(SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (out_free) begin
                    we       = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cpu <= (32'(req) >= NUM_CPUS) ? CPU_W'(32'(req) - NUM_CPUS) : CPU_W'(req);
            r_wr  <= i_s_tdata[2];
            r_tag <= tag_in;
            r_set <= SET_W'(tag_in % SETS);
        end
        if (r_state == S_EV && out_free) begin
            r_res <= ev_res;
        end
    end

    msc_ram #(
        .DEPTH (SETS),
        .AW    (SET_W),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (r_set),
        .o_rdata (rdata)
    );

    msc_eval #(
        .NUM_CPUS   (NUM_CPUS),
        .WAYS       (WAYS),
        .LINE_BYTES (LINE_BYTES),
        .CPU_W      (CPU_W),
        .TAG_W      (TAG_W),
        .AGE_W      (AGE_W),
        .ENT_W      (ENT_W)
    ) u_eval (
        .i_cpu   (r_cpu),
        .i_wr    (r_wr),
        .i_tag   (r_tag),
        .i_rword (rdata),
        .o_wword (ev_word),
        .o_res   (ev_res)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_res;

    a_acc_to_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_state == S_RD)
        else $error("transfer not followed by set read");
    a_rd_to_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |=> r_state == S_EV)
        else $error("set read not followed by update");
    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_CLR || (r_state == S_EV && out_free)))
        else $error("set write outside clear or update");
    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV && out_free) |=> o_m_tvalid)
        else $error("update did not present a result");

endmodule

// ===== tb/sv/mesi_snoop_coherence_top_tb.sv =====
// ---------------------------------------------------------------------------
// MESI snoop coherence testbench
// Drives read and write accesses from four CPUs over a small pool of lines
// and checks every result against a MESI tag/state/age predictor.
// ---------------------------------------------------------------------------
module mesi_snoop_coherence_top_tb;
    import msc_pkg::*;

    localparam int NCPU  = NUM_CPUS_D;
    localparam int NSET  = SETS_D;
    localparam int NWAY  = WAYS_D;
    localparam int LBYTE = LINE_BYTES_D;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;  // requester[1:0], mode[2], address[34:3]
    logic        o_m_tvalid;
    logic        i_m_tready;
    // status[2:0], mem_read_valid[3], mem_read_addr[35:4], writeback_valid[36],
    // writeback_addr[68:37], line_state[70:69], others_invalidated[71]
    logic [71:0] o_m_tdata;

    mesi_snoop_coherence_top dut (.*);

    logic [1:0]  cache_state [NCPU][NSET][NWAY];
    logic [25:0] cache_tag   [NCPU][NSET][NWAY];
    int          cache_age   [NCPU][NSET][NWAY];

    logic [39:0] access_q [$];
    t_result     result_q [$];
    int          mismatches = 0;
    int          cycles     = 0;
    bit          calm       = 0;
    bit          hold_sink  = 0;
    int          src_gap    = 0;
    int          snk_gap    = 0;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    function automatic int lookup(int c, int s, logic [25:0] t);
        for (int w = 0; w < NWAY; w++)
            if (cache_state[c][s][w] != ST_I && cache_tag[c][s][w] == t)
                return w;
        return -1;
    endfunction

    function automatic void make_recent(int c, int s, int w);
        int a;
        a = cache_age[c][s][w];
        for (int v = 0; v < NWAY; v++)
            if (cache_age[c][s][v] < a)
                cache_age[c][s][v]++;
        cache_age[c][s][w] = 0;
    endfunction

    function automatic t_result predict_access(logic [39:0] d);
        t_result     r;
        int          c, s, hit, ow, vw;
        logic        wr;
        logic [25:0] t;
        logic [1:0]  cur;
        bit          fill;
        r    = '0;
        fill = 0;
        c    = int'(d[1:0]) % NCPU;
        wr   = d[2];
        t    = 26'(d[34:3] / LBYTE);
        s    = int'(t) % NSET;
        hit  = lookup(c, s, t);
        if (!wr) begin
            if (hit >= 0) begin
                r.status = RS_READ_HIT;
                make_recent(c, s, hit);
                r.line_state = cache_state[c][s][hit];
            end else begin
                r.status = RS_MEM_READ;
                for (int o = 0; o < NCPU && r.status == RS_MEM_READ; o++) begin
                    if (o == c) continue;
                    ow = lookup(o, s, t);
                    if (ow >= 0) begin
                        if (cache_state[o][s][ow] == ST_S) begin
                            r.status = RS_MISS_SHR;
                        end else begin
                            cache_state[o][s][ow] = ST_S;
                            r.status = RS_MISS_OWN;
                        end
                    end
                end
                if (r.status == RS_MEM_READ) begin
                    r.mem_read_valid = 1;
                    r.mem_read_addr  = {t, 6'd0};
                    r.line_state     = ST_E;
                end else begin
                    r.line_state = ST_S;
                end
                fill = 1;
            end
        end else begin
            cur = (hit >= 0) ? cache_state[c][s][hit] : ST_I;
            if (cur == ST_M) begin
                r.status = RS_WRITE_HIT;
                make_recent(c, s, hit);
            end else begin
                for (int o = 0; o < NCPU; o++) begin
                    if (o == c) continue;
                    ow = lookup(o, s, t);
                    if (ow >= 0) begin
                        cache_state[o][s][ow] = ST_I;
                        r.others_invalidated = 1;
                    end
                end
                if (hit >= 0) begin
                    r.status = RS_UPGRADE;
                    cache_state[c][s][hit] = ST_M;
                    make_recent(c, s, hit);
                end else begin
                    r.status = RS_WRITE_MIS;
                    fill = 1;
                end
            end
            r.line_state = ST_M;
        end
        if (fill) begin
            vw = -1;
            for (int w = 0; w < NWAY && vw < 0; w++)
                if (cache_state[c][s][w] == ST_I) vw = w;
            if (vw < 0) begin
                vw = 0;
                for (int w = 1; w < NWAY; w++)
                    if (cache_age[c][s][w] > cache_age[c][s][vw]) vw = w;
            end
            if (cache_state[c][s][vw] == ST_M) begin
                r.writeback_valid = 1;
                r.writeback_addr  = {cache_tag[c][s][vw], 6'd0};
            end
            cache_tag[c][s][vw]   = t;
            cache_state[c][s][vw] = r.line_state;
            make_recent(c, s, vw);
        end
        return r;
    endfunction

    // a pool of lines spread over few sets, so misses, sharing and evictions meet
    function automatic logic [39:0] random_access();
        logic [31:0] a;
        int          s;
        s = (($urandom_range(0, 3) == 0) ? $urandom_range(0, NSET - 1) : $urandom_range(0, 2));
        a = 32'($urandom_range(0, 7) * 32'h0100_0000 + $urandom_range(0, 3) * 32'h1000);
        a = (a & ~32'hFFF) | 32'(s << 6) | 32'($urandom_range(0, LBYTE - 1));
        if ($urandom_range(0, 9) == 0) a = $urandom;
        return {5'd0, a, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))};
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mesi_snoop_coherence_top test failed");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                result_q.push_back(predict_access(i_s_tdata));
                access_q.pop_front();
            end
            if (src_gap > 0) begin
                src_gap    <= src_gap - 1;
                i_s_tvalid <= 0;
            end else if (!(i_s_tvalid && !o_s_tready) && !calm
                         && $urandom_range(0, 7) == 0) begin
                src_gap    <= $urandom_range(0, 2);
                i_s_tvalid <= 0;
            end else if (access_q.size() > 0) begin
                i_s_tvalid <= 1;
                i_s_tdata  <= access_q[0];
            end else begin
                i_s_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                if (result_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %h", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("result mismatch: expected %h got %h", want, got);
                    end
                end
            end
            if (hold_sink) begin
                i_m_tready <= 0;
            end else if (snk_gap > 0) begin
                snk_gap    <= snk_gap - 1;
                i_m_tready <= 0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                snk_gap    <= $urandom_range(0, 2);
                i_m_tready <= 0;
            end else begin
                i_m_tready <= 1;
            end
        end
    end

    task automatic wait_drained();
        while (access_q.size() > 0 || result_q.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
    endtask

    task automatic queue_access(int c, bit wr, logic [31:0] a);
        access_q.push_back({5'd0, a, wr, 2'(c)});
    endtask

    initial begin
        for (int c = 0; c < NCPU; c++)
            for (int s = 0; s < NSET; s++)
                for (int w = 0; w < NWAY; w++) begin
                    cache_state[c][s][w] = ST_I;
                    cache_tag[c][s][w]   = '0;
                    cache_age[c][s][w]   = w;
                end
        i_rst_n    = 0;
        i_s_tvalid = 0;
        i_s_tdata  = '0;
        i_m_tready = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // memory fill, hit, supply by E, by S, upgrade, write hit, write miss
        queue_access(0, 0, 32'h0000_0040);
        queue_access(0, 0, 32'h0000_007F);
        queue_access(1, 0, 32'h0000_0041);
        queue_access(2, 0, 32'h0000_0042);
        queue_access(1, 1, 32'h0000_0040);
        queue_access(1, 1, 32'h0000_0044);
        queue_access(3, 0, 32'h0000_0040);
        queue_access(2, 1, 32'h0000_0080);
        queue_access(3, 1, 32'hFFFF_FFFF);
        queue_access(3, 0, 32'hFFFF_FFC0);
        queue_access(0, 1, 32'h0000_0000);
        // fill set 0 of CPU 0 with modified lines, then evict
        for (int k = 1; k < 6; k++) queue_access(0, 1, k * 32'h1000);
        queue_access(0, 0, 32'h0000_0000);
        queue_access(1, 0, 32'h0000_1000);
        queue_access(2, 1, 32'h0000_2000);
        queue_access(0, 1, 32'h0000_6000);
        queue_access(1, 0, 32'hAAAA_AAAA);
        queue_access(2, 0, 32'h5555_5555);
        wait_drained();

        for (int k = 0; k < 400; k++) access_q.push_back(random_access());
        wait_drained();

        // stall the sink long enough to back up the pipeline
        hold_sink = 1;
        for (int k = 0; k < 60; k++) access_q.push_back(random_access());
        repeat (200) @(posedge i_clk);
        hold_sink = 0;
        wait_drained();

        for (int k = 0; k < 400; k++) access_q.push_back(random_access());
        wait_drained();

        calm = 1;
        for (int k = 0; k < 170; k++) access_q.push_back(random_access());
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && result_q.size() == 0)
            $display("mesi_snoop_coherence_top test passed");
        else
            $display("mesi_snoop_coherence_top test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/msc_pkg.sv
sv/msc_ram.sv
sv/msc_eval.sv
sv/mesi_snoop_coherence_top.sv
tb/sv/mesi_snoop_coherence_top_tb.sv
